FILE: hdl/spd_pkg.sv
package spd_pkg;

    localparam int RING_DEPTH_DEF = 32;

    localparam int MAG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int SCALED_W = 24;
    localparam int DET_W    = 25;
    localparam int BASE_W   = 40;
    localparam int QLEN_W   = 5;
    localparam int LVL_W    = 24;
    localparam int N_W      = 6;
    localparam int SUM_W    = 32;
    localparam int MA_W     = 17;
    localparam int MB_W     = 24;
    localparam int MP_W     = MA_W + MB_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QLEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QLEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLEVEL = 3'd7;

    localparam logic [15:0]       RST_SCALE  = 16'd256;
    localparam logic [15:0]       RST_ALPHA  = 16'd6554;
    localparam logic [31:0]       RST_REFR   = 32'd250000;
    localparam logic [31:0]       RST_IDLE   = 32'd2000000;
    localparam logic [QLEN_W-1:0] RST_QLEN   = 5'd8;
    localparam logic [LVL_W-1:0]  RST_QLEVEL = 24'd0;
    localparam logic [15:0]       RST_RATIO  = 16'd128;
    localparam logic [LVL_W-1:0]  RST_PLEVEL = 24'd0;

    typedef enum logic [4:0] {
        S_IDLE, S_MOD, S_SCALE, S_BLO, S_BHI, S_ALPHA, S_UPD, S_RD1, S_RD2,
        S_CHK, S_QRD, S_QACC, S_QMUL, S_QCMP, S_SHD, S_SCMP, S_EMIT, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        M_SCALE, M_BLO, M_BHI, M_ALPHA, M_QLVL, M_RATIO
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  mod_sub;
        t_msel msel;
        logic  cap_scaled;
        logic  cap_plo;
        logic  cap_phi;
        logic  update;
        logic  rd;
        logic  cap_xm1;
        logic  chk;
        logic  qacc;
        logic  emit;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic wpos_ge_len;
        logic cand;
        logic ok;
        logic idle;
        logic cnt_ge3;
        logic rem_zero;
        logic quiet_fail;
        logic lp_zero;
        logic shoulder_fail;
        logic out_free;
    } t_sts;

    function automatic logic [DET_W-1:0] abs_det(input logic signed [DET_W-1:0] v);
        abs_det = v[DET_W-1] ? DET_W'(-v) : DET_W'(v);
    endfunction

endpackage

FILE: hdl/spd_ctrl.sv
module spd_ctrl import spd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MOD;
            S_MOD:   if (!i_sts.wpos_ge_len) n_state = S_SCALE;
            S_SCALE: n_state = S_BLO;
            S_BLO:   n_state = S_BHI;
            S_BHI:   n_state = S_ALPHA;
            S_ALPHA: n_state = S_UPD;
            S_UPD:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_CHK;
            S_CHK: begin
                priority if (!i_sts.cand || !i_sts.ok) n_state = S_FIN;
                else if (!i_sts.idle)                  n_state = S_EMIT;
                else if (i_sts.cnt_ge3)                n_state = S_QRD;
                else                                   n_state = S_SHD;
            end
            S_QRD:   n_state = S_QACC;
            S_QACC:  n_state = i_sts.rem_zero ? S_QMUL : S_QRD;
            S_QMUL:  n_state = S_QCMP;
            S_QCMP:  n_state = i_sts.quiet_fail ? S_FIN : S_SHD;
            S_SHD:   n_state = i_sts.lp_zero ? S_EMIT : S_SCMP;
            S_SCMP:  n_state = i_sts.shoulder_fail ? S_FIN : S_EMIT;
            S_EMIT:  if (i_sts.out_free) n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.msel = M_SCALE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MOD:   o_cmd.mod_sub = i_sts.wpos_ge_len;
            S_SCALE: o_cmd.msel = M_SCALE;
            S_BLO: begin
                o_cmd.msel       = M_BLO;
                o_cmd.cap_scaled = 1'b1;
            end
            S_BHI: begin
                o_cmd.msel    = M_BHI;
                o_cmd.cap_plo = 1'b1;
            end
            S_ALPHA: begin
                o_cmd.msel    = M_ALPHA;
                o_cmd.cap_phi = 1'b1;
            end
            S_UPD:   o_cmd.update = 1'b1;
            S_RD1:   o_cmd.rd = 1'b1;
            S_RD2: begin
                o_cmd.rd      = 1'b1;
                o_cmd.cap_xm1 = 1'b1;
            end
            S_CHK:   o_cmd.chk = 1'b1;
            S_QRD:   o_cmd.rd = 1'b1;
            S_QACC:  o_cmd.qacc = 1'b1;
            S_QMUL:  o_cmd.msel = M_QLVL;
            S_QCMP:  o_cmd.msel = M_QLVL;
            S_SHD:   o_cmd.msel = M_RATIO;
            S_SCMP:  o_cmd.msel = M_RATIO;
            S_EMIT:  o_cmd.emit = i_sts.out_free;
            S_FIN:   o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/spd_datapath.sv
module spd_datapath import spd_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [MAG_W-1:0]     i_magnitude,
    input  logic [TIME_W-1:0]    i_sample_time_us,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2*TIME_W-1:0]  o_out_data
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LW = $clog2(RING_DEPTH + 1);

    // configuration
    logic [15:0]       r_scale, r_alpha, r_ratio;
    logic [31:0]       r_refr, r_idle;
    logic [QLEN_W-1:0] r_qlen;
    logic [LVL_W-1:0]  r_qlevel, r_plevel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= RST_SCALE;
            r_alpha  <= RST_ALPHA;
            r_refr   <= RST_REFR;
            r_idle   <= RST_IDLE;
            r_qlen   <= RST_QLEN;
            r_qlevel <= RST_QLEVEL;
            r_ratio  <= RST_RATIO;
            r_plevel <= RST_PLEVEL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCALE:  r_scale  <= i_cfg_data[15:0];
                REG_ALPHA:  r_alpha  <= i_cfg_data[15:0];
                REG_REFR:   r_refr   <= i_cfg_data;
                REG_IDLE:   r_idle   <= i_cfg_data;
                REG_QLEN:   r_qlen   <= i_cfg_data[QLEN_W-1:0];
                REG_QLEVEL: r_qlevel <= i_cfg_data[LVL_W-1:0];
                REG_RATIO:  r_ratio  <= i_cfg_data[15:0];
                REG_PLEVEL: r_plevel <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // ring length, capped at the memory depth
    logic [QLEN_W:0] qlen_p3;
    logic [LW-1:0]   len;
    assign qlen_p3 = {1'b0, r_qlen} + (QLEN_W+1)'(3);
    assign len = (int'(qlen_p3) > RING_DEPTH) ? LW'(RING_DEPTH) : LW'(qlen_p3);

    function automatic logic [IW-1:0] dec_slot(input logic [IW-1:0] p, input logic [LW-1:0] l);
        logic [LW-1:0] t;
        t = l - LW'(1);
        dec_slot = (p == '0) ? t[IW-1:0] : p - IW'(1);
    endfunction

    // item registers
    logic [MAG_W-1:0]    r_mag;
    logic [TIME_W-1:0]   r_ts;
    logic [SCALED_W-1:0] r_scaled;
    logic [MP_W-1:0]     r_prod;
    logic [36:0]         r_plo, r_phi;
    logic signed [DET_W-1:0] r_det, r_xm1;
    logic [IW-1:0]       r_ptr;
    logic [SUM_W-1:0]    r_sum;
    logic [QLEN_W-1:0]   r_rem, r_count;

    // state
    logic [BASE_W-1:0]   r_base;
    logic                r_seeded;
    logic [IW-1:0]       r_wpos;
    logic [N_W-1:0]      r_n;
    logic [TIME_W-1:0]   r_prev_time, r_last_time, r_step_ctr;
    logic                r_have_step;
    logic [LVL_W-1:0]    r_last_peak;

    // shared multiplier, one product per cycle
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [MA_W-1:0] alpha_c;
    assign alpha_c = 17'h10000 - {1'b0, r_alpha};

    always_comb begin
        unique case (i_cmd.msel)
            M_SCALE: begin mul_a = {1'b0, r_scale};     mul_b = MB_W'(r_mag);          end
            M_BLO:   begin mul_a = alpha_c;             mul_b = MB_W'(r_base[19:0]);   end
            M_BHI:   begin mul_a = alpha_c;             mul_b = MB_W'(r_base[39:20]);  end
            M_ALPHA: begin mul_a = {1'b0, r_alpha};     mul_b = r_scaled;              end
            M_QLVL:  begin mul_a = MA_W'(r_count);      mul_b = r_qlevel;              end
            M_RATIO: begin mul_a = {1'b0, r_ratio};     mul_b = r_last_peak;           end
            default: begin mul_a = '0;                  mul_b = '0;                    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MP_W'(mul_a) * MP_W'(mul_b);
    end

    // baseline update: alpha*scaled + ((65536-alpha)*baseline >> 16); the first sample seeds it with scaled << 16
    logic [BASE_W+1:0]   base_sum;
    logic [BASE_W-1:0]   new_base;
    logic signed [DET_W-1:0] new_det;
    assign base_sum = (BASE_W+2)'(r_prod[BASE_W-1:0]) + (BASE_W+2)'({r_phi, 4'b0000})
                    + (BASE_W+2)'(r_plo[36:16]);
    assign new_base = r_seeded ? base_sum[BASE_W-1:0] : {r_scaled, 16'h0000};
    assign new_det  = r_seeded ? ({1'b0, r_scaled} - {1'b0, new_base[39:16]}) : '0;

    // ring memory with per-entry valid bits
    logic signed [DET_W-1:0] ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]   r_ring_vld;
    logic signed [DET_W-1:0] r_rdata;
    logic                    r_rvld;
    logic signed [DET_W-1:0] rd_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) ring[r_wpos] <= new_det;
        if (i_cmd.rd) r_rdata <= ring[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
        end else if (i_cmd.update) begin
            r_ring_vld[r_wpos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rvld <= r_ring_vld[r_ptr];
    end

    assign rd_val = r_rvld ? r_rdata : '0;

    // peak tests
    logic [DET_W-1:0]  pk;
    logic [TIME_W-1:0] dt;
    logic [N_W-1:0]    n_m1;
    logic [QLEN_W-1:0] count;
    logic [LW-1:0]     wpos_ext, wpos_inc;
    assign pk       = abs_det(r_xm1);
    assign dt       = r_prev_time - r_last_time;
    assign n_m1     = r_n - N_W'(1);
    assign count    = (n_m1 > N_W'(r_qlen)) ? r_qlen : n_m1[QLEN_W-1:0];
    assign wpos_ext = LW'(r_wpos);
    assign wpos_inc = wpos_ext + LW'(1);

    always_comb begin
        o_sts.wpos_ge_len   = (wpos_ext >= len);
        o_sts.cand          = (r_n >= N_W'(2)) && (rd_val < r_xm1) && (r_xm1 > r_det)
                              && (pk >= DET_W'(r_plevel));
        o_sts.ok            = !r_have_step || (dt >= r_refr);
        o_sts.idle          = r_have_step && (dt > r_idle);
        o_sts.cnt_ge3       = (count >= QLEN_W'(3));
        o_sts.rem_zero      = (r_rem == '0);
        o_sts.quiet_fail    = (MP_W'(r_sum) < r_prod);
        o_sts.lp_zero       = (r_last_peak == '0);
        o_sts.shoulder_fail = (MP_W'({pk, 8'h00}) < r_prod);
        o_sts.out_free      = !o_out_valid || i_out_ready;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= i_magnitude;
            r_ts  <= i_sample_time_us;
        end
        if (i_cmd.cap_scaled) r_scaled <= r_prod[SCALED_W+7:8];
        if (i_cmd.cap_plo)    r_plo    <= r_prod[36:0];
        if (i_cmd.cap_phi)    r_phi    <= r_prod[36:0];
        if (i_cmd.update) begin
            r_det <= new_det;
            r_ptr <= dec_slot(r_wpos, len);
        end else if (i_cmd.rd) begin
            r_ptr <= dec_slot(r_ptr, len);
        end
        if (i_cmd.cap_xm1) r_xm1 <= rd_val;
        if (i_cmd.chk) begin
            r_sum   <= SUM_W'(abs_det(rd_val));
            r_rem   <= count - QLEN_W'(1);
            r_count <= count;
        end else begin
            if (i_cmd.rd)   r_rem <= r_rem - QLEN_W'(1);
            if (i_cmd.qacc) r_sum <= r_sum + SUM_W'(abs_det(rd_val));
        end
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_seeded    <= 1'b0;
            r_wpos      <= '0;
            r_n         <= '0;
            r_prev_time <= '0;
            r_last_time <= '0;
            r_step_ctr  <= '0;
            r_have_step <= 1'b0;
            r_last_peak <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mod_sub) r_wpos <= IW'(wpos_ext - len);
            if (i_cmd.update) begin
                r_base   <= new_base;
                r_seeded <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                r_step_ctr  <= r_step_ctr + TIME_W'(1);
                r_last_time <= r_prev_time;
                r_have_step <= 1'b1;
                r_last_peak <= pk[LVL_W-1:0];
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_prev_time <= r_ts;
                if (r_n != '1) r_n <= r_n + N_W'(1);
                r_wpos <= (wpos_inc == len) ? '0 : IW'(wpos_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) o_out_data <= {r_step_ctr, r_prev_time};
    end

endmodule

FILE: hdl/step_peak_detector.sv
// step peak detector
// input stream: one word per accelerometer sample (magnitude, timestamp in us).
// output stream: one word per detected step (peak timestamp, running step number).
// config channel: register index and data, always ready; the user must write
// it only while idle, since the block itself does not enforce this. each sample
// runs through a sequencer around one shared 17x24 multiplier: scale, two
// partial products of the baseline average, alpha term, then two ring memory
// reads for the local-maximum check, a check state and a finish state, plus an
// emit state when it emits a step. a candidate in idle mode adds a read and an
// accumulate state per further quiet-window entry (count-1 entries, up to 30)
// plus the multiply and compare states. after a window length change the write
// pointer is folded back by repeated subtraction of the ring length.
// a new sample is taken once the previous one is finished; a step result
// sits in an output register, and the sequencer waits only if a second step
// is ready while the first is still not taken by the receiver.
// reset clears the configuration to defaults, the baseline, counters and
// the ring valid bits (unwritten ring entries read as zero).
module step_peak_detector import spd_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [47:0]          i_s_axis_tdata,   // magnitude[15:0], sample_time_us[47:16]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [63:0]          o_m_axis_tdata,   // step_time_us[31:0], step_number[63:32]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    spd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    spd_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_magnitude      (i_s_axis_tdata[15:0]),
        .i_sample_time_us (i_s_axis_tdata[47:16]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_out_data       (o_m_axis_tdata)
    );

endmodule
